[rtl/mhd_pkg.sv]
package mhd_pkg;

  // Configuration port geometry
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 31;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_MAGIC      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAJOR      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SET_MARKER = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ACK_MARKER = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SET_ORDER  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_RECV_BUF   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_SOCK_BUF   = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_INIT_BIG   = 3'd7;

  // Width of the acknowledge difference, wide enough to never wrap
  localparam int DiffW = 35;

  localparam logic [30:0] IntMax   = 31'h7FFF_FFFF;
  localparam logic [63:0] Int64Max = 64'h7FFF_FFFF_FFFF_FFFF;

  // Byte order after reset
  localparam logic InitBigEndianReset = 1'b1;

  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_PAYLOAD   = 3'd1,
    KIND_DATA_DONE = 3'd2,
    KIND_CTRL_DONE = 3'd3,
    KIND_ERROR     = 3'd4,
    KIND_IGNORED   = 3'd5
  } kind_e;

  typedef struct packed {
    logic [7:0]  magic_value;
    logic [3:0]  major_revision;
    logic [7:0]  set_marker_code;
    logic [7:0]  ack_marker_code;
    logic [7:0]  set_order_code;
    logic [30:0] remote_recv_buffer;
    logic [30:0] remote_socket_buffer;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    magic_value:          8'd202,
    major_revision:       4'd0,
    set_marker_code:      8'd0,
    ack_marker_code:      8'd1,
    set_order_code:       8'd2,
    remote_recv_buffer:   31'd16384,
    remote_socket_buffer: 31'd16384
  };

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [30:0] tx_total_sent;
    logic        marker_taken;
  } in_item_t;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         payload_byte;
    logic               last_payload;
    logic [7:0]         command;
    logic [7:0]         version;
    logic signed [31:0] payload_size;
    logic [1:0]         segment_bits;
    logic signed [31:0] pending_marker;
    logic signed [63:0] remote_free_space;
    logic               big_endian;
  } result_t;

  // Word handed from the parser to the back end
  typedef struct packed {
    result_t                res;
    logic                   ack;
    logic signed [DiffW-1:0] ack_diff;
  } mid_t;

endpackage

[rtl/mhd_fifo.sv]
module mhd_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             wr, rd;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign wr      = push_i && !full_o;
  assign rd      = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({wr, rd})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue fill level above depth");

endmodule

[rtl/mhd_front.sv]
module mhd_front import mhd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     order_wr_i,
  input  logic     order_val_i,
  input  logic     item_valid_i,
  input  in_item_t item_i,
  output logic     item_full_o,
  output logic     mid_push_o,
  output mid_t     mid_o,
  input  logic     mid_full_i
);

  // Header byte positions and packet types
  localparam logic [2:0] HDR_MAGIC   = 3'd0;
  localparam logic [2:0] HDR_VERSION = 3'd1;
  localparam logic [2:0] HDR_FLAGS   = 3'd2;
  localparam logic [2:0] HDR_COMMAND = 3'd3;
  localparam logic [2:0] HDR_LAST    = 3'd7;
  localparam logic [3:0] TYPE_DATA   = 4'd0;
  localparam logic [3:0] TYPE_CTRL   = 4'd1;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CLOSED  = 2'd2
  } phase_e;

  phase_e       phase_q, phase_d;
  logic [2:0]   idx_q, idx_d;
  logic [7:0]   version_q, version_d;
  logic [7:0]   flags_q, flags_d;
  logic [7:0]   command_q, command_d;
  logic [31:0]  size_q, size_d;
  logic [30:0]  left_q, left_d;
  logic [31:0]  marker_q, marker_d;
  logic         order_q, order_d;

  kind_e             kind;
  logic [7:0]        pbyte;
  logic              last;
  logic              do_ack;
  logic              accept;
  logic [7:0]        b;
  logic signed [DiffW-1:0] diff;

  assign b           = item_i.rx_byte;
  assign accept      = item_valid_i && !mid_full_i;
  assign item_full_o = mid_full_i;

  // Parse one byte and work out the next state
  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    version_d = version_q;
    flags_d   = flags_q;
    command_d = command_q;
    size_d    = size_q;
    left_d    = left_q;
    marker_d  = item_i.marker_taken ? '0 : marker_q;
    order_d   = order_q;
    kind      = KIND_IGNORED;
    pbyte     = '0;
    last      = 1'b0;
    do_ack    = 1'b0;
    case (phase_q)
      PH_HEADER: begin
        kind = KIND_HEADER;
        case (idx_q)
          HDR_MAGIC: begin
            if (b != cfg_i.magic_value) begin
              kind = KIND_ERROR;
            end else begin
              size_d = '0;
            end
          end
          HDR_VERSION: begin
            version_d = b;
            if (b[7:4] != cfg_i.major_revision) begin
              kind = KIND_ERROR;
            end
          end
          HDR_FLAGS:   flags_d = b;
          HDR_COMMAND: command_d = b;
          default: begin
            if (order_q) begin
              size_d = {size_q[23:0], b};
            end else begin
              size_d = size_q | (32'(b) << {idx_q[1:0], 3'b000});
            end
          end
        endcase
        if (kind == KIND_ERROR) begin
          phase_d = PH_CLOSED;
          idx_d   = '0;
          left_d  = '0;
        end else if (idx_q == HDR_LAST) begin
          idx_d = '0;
          // Act on the complete header
          case (flags_d[3:0])
            TYPE_DATA: begin
              if (size_d[31]) begin
                kind    = KIND_ERROR;
                phase_d = PH_CLOSED;
                left_d  = '0;
              end else begin
                kind    = KIND_DATA_DONE;
                left_d  = size_d[30:0];
                phase_d = (size_d[30:0] != '0) ? PH_PAYLOAD : PH_HEADER;
              end
            end
            TYPE_CTRL: begin
              kind = KIND_CTRL_DONE;
              if (command_d == cfg_i.set_marker_code) begin
                if (marker_d == '0) begin
                  marker_d = size_d;
                end
              end else if (command_d == cfg_i.ack_marker_code) begin
                do_ack = 1'b1;
              end else if (command_d == cfg_i.set_order_code) begin
                order_d = flags_d[7];
              end
            end
            default: begin
              kind    = KIND_ERROR;
              phase_d = PH_CLOSED;
              left_d  = '0;
            end
          endcase
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      PH_PAYLOAD: begin
        kind  = KIND_PAYLOAD;
        pbyte = b;
        if (left_q <= 31'd1) begin
          last    = 1'b1;
          left_d  = '0;
          phase_d = PH_HEADER;
        end else begin
          left_d = left_q - 1'b1;
        end
      end
      default: begin
        kind = KIND_IGNORED;
      end
    endcase
  end

  // Raw acknowledge difference: sent count minus signed size plus header length
  assign diff = $signed({4'b0000, item_i.tx_total_sent})
              - $signed({{(DiffW - 32){size_d[31]}}, size_d})
              + DiffW'(8);

  // Build the word for the back end
  always_comb begin
    mid_o.res.kind              = kind;
    mid_o.res.payload_byte      = pbyte;
    mid_o.res.last_payload      = last;
    mid_o.res.command           = command_d;
    mid_o.res.version           = version_d;
    mid_o.res.payload_size      = size_d;
    mid_o.res.segment_bits      = flags_d[5:4];
    mid_o.res.pending_marker    = marker_d;
    mid_o.res.remote_free_space = '0;
    mid_o.res.big_endian        = order_d;
    mid_o.ack                   = do_ack;
    mid_o.ack_diff              = diff;
  end

  assign mid_push_o = accept;

  // Hold parser state, advance on each accepted word unless the byte order is being written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      idx_q     <= '0;
      version_q <= '0;
      flags_q   <= '0;
      command_q <= '0;
      size_q    <= '0;
      left_q    <= '0;
      marker_q  <= '0;
      order_q   <= InitBigEndianReset;
    end else if (order_wr_i) begin
      order_q <= order_val_i;
    end else if (accept) begin
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      version_q <= version_d;
      flags_q   <= flags_d;
      command_q <= command_d;
      size_q    <= size_d;
      left_q    <= left_d;
      marker_q  <= marker_d;
      order_q   <= order_d;
    end
  end

  a_closed_sticks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_CLOSED |=> phase_q == PH_CLOSED)
    else $error("parser left the disconnected state");

  a_payload_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> left_q != '0)
    else $error("payload phase with no bytes left");

  a_idx_in_header : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != '0 |-> phase_q == PH_HEADER)
    else $error("header index running outside header phase");

endmodule

[rtl/mhd_back.sv]
module mhd_back import mhd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    mid_empty_i,
  input  mid_t    mid_i,
  output logic    mid_pop_o,
  output logic    empty_o,
  input  logic    pop_i,
  output result_t res_o
);

  logic                     valid_q;
  logic [63:0]              free_q;
  logic [63:0]              free_new;
  result_t                  res_q;
  result_t                  res_new;
  logic                     load;
  logic [31:0]              buf_sum;
  logic signed [DiffW-1:0]  corr;
  logic signed [DiffW-1:0]  fs;

  assign load      = !mid_empty_i && (!valid_q || pop_i);
  assign mid_pop_o = load;
  assign empty_o   = !valid_q;
  assign res_o     = res_q;

  // Fold a negative difference and subtract it from the buffer total
  assign buf_sum = {1'b0, cfg_i.remote_recv_buffer} + {1'b0, cfg_i.remote_socket_buffer};
  assign corr    = mid_i.ack_diff[DiffW-1]
                 ? mid_i.ack_diff + $signed(DiffW'(IntMax))
                 : mid_i.ack_diff;
  assign fs      = $signed(DiffW'(buf_sum)) - corr;
  assign free_new = mid_i.ack ? {{(64 - DiffW){fs[DiffW-1]}}, fs} : free_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      free_q  <= Int64Max;
    end else if (load) begin
      valid_q <= 1'b1;
      free_q  <= free_new;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  // Merge the new free space into the result word
  always_comb begin
    res_new                   = mid_i.res;
    res_new.remote_free_space = free_new;
  end

  // Capture the result word
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_new;
    end
  end

  a_free_only_on_ack : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(load && mid_i.ack) |=> $stable(free_q))
    else $error("free space changed without an acknowledge");

endmodule

[rtl/message_header_deframer.sv]
// Message header deframer: takes one received byte per word and parses
// 8-byte headers (magic, version, flags, command, 32-bit size in the current
// byte order), passes data payload bytes out with the last one marked, and
// acts on control packets (set marker, acknowledge marker, set byte order)
// as their header completes. A bad magic or major version, an unknown packet
// type or a negative data size disconnects; every later byte then returns
// kind "ignored" until reset. Each input word yields exactly one result word.
// Sustained rate is one word per clock on both sides while the result side
// keeps popping; the per-byte header and counter update in the parser sets
// that figure. An accepted word goes into the queue between parser and back
// end, where it waits while the result side stalls, then into the result register.
// Configuration may be written only while no word is in flight.
module message_header_deframer import mhd_pkg::*; #(
  parameter int MidDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  in_item_t            item_i,
  output logic                empty,
  input  logic                pop,
  output result_t             result_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t cfg_q;
  logic order_wr;
  logic mid_push, mid_full, mid_pop, mid_empty;
  mid_t mid_in, mid_out;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAGIC:      cfg_q.magic_value          <= cfg_data_i[7:0];
        CFG_MAJOR:      cfg_q.major_revision       <= cfg_data_i[3:0];
        CFG_SET_MARKER: cfg_q.set_marker_code      <= cfg_data_i[7:0];
        CFG_ACK_MARKER: cfg_q.ack_marker_code      <= cfg_data_i[7:0];
        CFG_SET_ORDER:  cfg_q.set_order_code       <= cfg_data_i[7:0];
        CFG_RECV_BUF:   cfg_q.remote_recv_buffer   <= cfg_data_i[30:0];
        CFG_SOCK_BUF:   cfg_q.remote_socket_buffer <= cfg_data_i[30:0];
        default: begin
        end
      endcase
    end
  end

  // Writing the initial byte order reloads the live byte order
  assign order_wr = cfg_we_i && (cfg_idx_i == CFG_INIT_BIG);

  mhd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .order_wr_i   (order_wr),
    .order_val_i  (cfg_data_i[0]),
    .item_valid_i (push),
    .item_i       (item_i),
    .item_full_o  (full),
    .mid_push_o   (mid_push),
    .mid_o        (mid_in),
    .mid_full_i   (mid_full)
  );

  mhd_fifo #(
    .Width ($bits(mid_t)),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty)
  );

  mhd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mid_empty_i (mid_empty),
    .mid_i       (mid_out),
    .mid_pop_o   (mid_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (result_o)
  );

endmodule
